FILE: hdl/utf8_column_wrap_counter_core_defines.svh
// ----------------------------------------------------------------------------
// UTF-8 column wrap counter: assertion macros
// Shared property shorthands; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef UTF8_COLUMN_WRAP_COUNTER_CORE_DEFINES_SVH
`define UTF8_COLUMN_WRAP_COUNTER_CORE_DEFINES_SVH

// Same-cycle implication.
`define UCW_ASSERT_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ucw: same-cycle check failed");

// Next-cycle implication.
`define UCW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ucw: next-cycle check failed");

`endif

FILE: hdl/ucw_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 column wrap counter: package
// Shared op type, queue sizing, byte class constants and width lookup.
// ----------------------------------------------------------------------------
package ucw_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam int CP_BITS = 21;
  localparam int WW_BITS = 11;

  localparam logic [WW_BITS-1:0] WRAP_WIDTH_RESET = 11'd80;

  // item_kind codes
  localparam logic KIND_POINT   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // byte classes
  localparam logic [7:0] CONT_MASK    = 8'hC0;
  localparam logic [7:0] CONT_TAG     = 8'h80;
  localparam logic [7:0] LEAD2_MASK   = 8'hE0;
  localparam logic [7:0] LEAD2_TAG    = 8'hC0;
  localparam logic [7:0] LEAD3_MASK   = 8'hF0;
  localparam logic [7:0] LEAD3_TAG    = 8'hE0;
  localparam logic [7:0] LEAD4_MASK   = 8'hF8;
  localparam logic [7:0] LEAD4_TAG    = 8'hF0;
  localparam logic [7:0] NUL_BYTE     = 8'h00;

  // zero-width ranges
  localparam logic [CP_BITS-1:0] CTRL_END  = 21'd32;
  localparam logic [CP_BITS-1:0] DEL_CP    = 21'h7F;
  localparam logic [CP_BITS-1:0] C1_END    = 21'hA0;
  localparam logic [CP_BITS-1:0] COMB_LO   = 21'h0300;
  localparam logic [CP_BITS-1:0] COMB_HI   = 21'h036F;

  typedef struct packed {
    logic               kind;
    logic [CP_BITS-1:0] cp;
    logic [2:0]         nbytes;
    logic               last;
  } ucw_op_t;

  function automatic logic point_width(input logic [CP_BITS-1:0] cp);
    logic w;
    w = 1'b1;
    if (cp < CTRL_END) w = 1'b0;
    if (cp >= DEL_CP && cp < C1_END) w = 1'b0;
    if (cp >= COMB_LO && cp <= COMB_HI) w = 1'b0;
    return w;
  endfunction

endpackage

FILE: hdl/ucw_intf.sv
// ----------------------------------------------------------------------------
// UTF-8 column wrap counter: channel interfaces
// Input byte, result and wrap width channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ucw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_line;

  modport source (output valid, output text_byte, output end_of_line, input ready);
  modport sink   (input valid, input text_byte, input end_of_line, output ready);
endinterface

interface ucw_out_if #(parameter int COUNT_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic                  item_kind;
  logic [20:0]           code_point;
  logic [2:0]            byte_count;
  logic                  display_width;
  logic [COUNT_BITS-1:0] start_column;
  logic [COUNT_BITS-1:0] row_index;
  logic                  starts_new_row;
  logic [COUNT_BITS-1:0] total_columns;
  logic [COUNT_BITS-1:0] visual_lines;
  logic                  last_of_run;

  modport source (output valid, output item_kind, output code_point, output byte_count,
                  output display_width, output start_column, output row_index,
                  output starts_new_row, output total_columns, output visual_lines,
                  output last_of_run, input ready);
  modport sink   (input valid, input item_kind, input code_point, input byte_count,
                  input display_width, input start_column, input row_index,
                  input starts_new_row, input total_columns, input visual_lines,
                  input last_of_run, output ready);
endinterface

interface ucw_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] wrap_width;

  modport source (output valid, output wrap_width, input ready);
  modport sink   (input valid, input wrap_width, output ready);
endinterface

FILE: hdl/ucw_queue.sv
// ----------------------------------------------------------------------------
// UTF-8 column wrap counter: op queue
// Small register FIFO between the decode front and the counting back.
// ----------------------------------------------------------------------------
`include "utf8_column_wrap_counter_core_defines.svh"

module ucw_queue
  import ucw_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  ucw_op_t push_op,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output ucw_op_t head_op
);

  ucw_op_t             mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp_r;
  logic [QUEUE_AW-1:0] rp_r;
  logic [QUEUE_AW:0]   cnt_r;

  assign full       = (cnt_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_op    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `UCW_ASSERT_HOLDS(qu_no_overrun, push || pop, !(push && full) && !(pop && !head_valid))

endmodule

FILE: hdl/ucw_div.sv
// ----------------------------------------------------------------------------
// UTF-8 column wrap counter: row divider
// Restoring divider, one quotient bit per cycle, for the visual line count.
// ----------------------------------------------------------------------------
module ucw_div
  import ucw_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [COUNT_BITS-1:0] dividend,
  input  logic [WW_BITS-1:0]    divisor,
  output logic                  busy,
  output logic [COUNT_BITS-1:0] quo,
  output logic                  rem_nz
);

  localparam int CW = $clog2(COUNT_BITS + 1);

  logic [COUNT_BITS-1:0] quo_r;
  logic [WW_BITS-1:0]    rem_r;
  logic [WW_BITS-1:0]    dvs_r;
  logic [CW-1:0]         cnt_r;

  logic [WW_BITS:0]      trial;
  logic [WW_BITS:0]      diff;
  logic                  qbit;

  assign trial = {rem_r, quo_r[COUNT_BITS-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign qbit  = (trial >= {1'b0, dvs_r});

  assign busy   = (cnt_r != '0);
  assign quo    = quo_r;
  assign rem_nz = (rem_r != '0);

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy) begin
      quo_r <= {quo_r[COUNT_BITS-2:0], qbit};
      rem_r <= qbit ? diff[WW_BITS-1:0] : trial[WW_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(COUNT_BITS);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

FILE: hdl/ucw_front.sv
// ----------------------------------------------------------------------------
// UTF-8 column wrap counter: decode front
// Collects UTF-8 sequences, expands each byte into a short op list and
// feeds the ops into the queue one per cycle while the queue is not full.
// ----------------------------------------------------------------------------
`include "utf8_column_wrap_counter_core_defines.svh"

module ucw_front
  import ucw_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  ucw_in_if.sink  in_ch,
  output logic    q_push,
  output ucw_op_t q_op,
  input  logic    q_full
);

  // sequence state
  logic [2:0][7:0] pend_b_r;
  logic [1:0]      pend_cnt_r;
  logic [2:0]      exp_len_r;
  logic            drop_r;

  // op list of the word being expanded
  logic [2:0][7:0]     pre_b_r;
  logic [1:0]          pre_cnt_r;
  logic                mid_v_r;
  logic [CP_BITS-1:0]  mid_cp_r;
  logic [2:0]          mid_nb_r;
  logic [2:0][7:0]     post_b_r;
  logic [1:0]          post_cnt_r;
  logic                sum_r;
  logic [2:0]          rem_r;
  logic [2:0]          slot_r;

  // decode of the incoming word
  logic [7:0]          b;
  logic                eol;
  logic                is_cont;
  logic                fresh;
  logic [2:0][7:0]     pend_b_nxt;
  logic [1:0]          pend_cnt_nxt;
  logic [2:0]          exp_len_nxt;
  logic                drop_nxt;
  logic [1:0]          d_pre_cnt;
  logic                d_mid_v;
  logic [CP_BITS-1:0]  d_mid_cp;
  logic [2:0]          d_mid_nb;
  logic [1:0]          d_post_cnt;
  logic                d_sum;
  logic [2:0]          d_total;
  logic                accept;

  assign b       = in_ch.text_byte;
  assign eol     = in_ch.end_of_line;
  assign is_cont = ((b & CONT_MASK) == CONT_TAG);

  always_comb begin
    d_pre_cnt    = '0;
    d_mid_v      = 1'b0;
    d_mid_cp     = '0;
    d_mid_nb     = '0;
    d_post_cnt   = '0;
    d_sum        = 1'b0;
    pend_b_nxt   = pend_b_r;
    pend_cnt_nxt = pend_cnt_r;
    exp_len_nxt  = exp_len_r;
    drop_nxt     = drop_r;
    fresh        = 1'b0;
    if (drop_r) begin
      if (eol) drop_nxt = 1'b0;
    end else if (b == NUL_BYTE) begin
      d_pre_cnt    = pend_cnt_r;
      d_sum        = 1'b1;
      pend_cnt_nxt = '0;
      exp_len_nxt  = '0;
      drop_nxt     = !eol;
    end else begin
      if (pend_cnt_r != '0) begin
        if (is_cont && pend_cnt_r != 2'd3) begin
          if (pend_cnt_r == 2'd1) pend_b_nxt[1] = b;
          else                    pend_b_nxt[2] = b;
          pend_cnt_nxt = pend_cnt_r + 2'd1;
          if ({1'b0, pend_cnt_nxt} == exp_len_r) begin
            d_mid_v  = 1'b1;
            d_mid_nb = exp_len_r;
            if (exp_len_r == 3'd2) begin
              d_mid_cp = {10'd0, pend_b_r[0][4:0], b[5:0]};
            end else begin
              d_mid_cp = {5'd0, pend_b_r[0][3:0], pend_b_r[1][5:0], b[5:0]};
            end
            pend_cnt_nxt = '0;
            exp_len_nxt  = '0;
          end
        end else if (is_cont) begin
          d_mid_v      = 1'b1;
          d_mid_nb     = 3'd4;
          d_mid_cp     = {pend_b_r[0][2:0], pend_b_r[1][5:0], pend_b_r[2][5:0], b[5:0]};
          pend_cnt_nxt = '0;
          exp_len_nxt  = '0;
        end else begin
          // broken sequence: flush buffered bytes, then decode this one
          d_pre_cnt    = pend_cnt_r;
          pend_cnt_nxt = '0;
          exp_len_nxt  = '0;
          fresh        = 1'b1;
        end
      end else begin
        fresh = 1'b1;
      end

      if (fresh) begin
        if ((b & LEAD2_MASK) == LEAD2_TAG) begin
          pend_b_nxt[0] = b;
          pend_cnt_nxt  = 2'd1;
          exp_len_nxt   = 3'd2;
        end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
          pend_b_nxt[0] = b;
          pend_cnt_nxt  = 2'd1;
          exp_len_nxt   = 3'd3;
        end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
          pend_b_nxt[0] = b;
          pend_cnt_nxt  = 2'd1;
          exp_len_nxt   = 3'd4;
        end else begin
          // ASCII or a stray byte goes out as a single
          d_mid_v  = 1'b1;
          d_mid_nb = 3'd1;
          d_mid_cp = {13'd0, b};
        end
      end

      if (eol) begin
        d_post_cnt   = pend_cnt_nxt;
        d_sum        = 1'b1;
        pend_cnt_nxt = '0;
        exp_len_nxt  = '0;
      end
    end
  end

  assign d_total = {1'b0, d_pre_cnt} + {2'd0, d_mid_v} + {1'b0, d_post_cnt} + {2'd0, d_sum};

  // take a new word while the last op of the current one leaves
  assign q_push      = (rem_r != '0) && !q_full;
  assign in_ch.ready = (rem_r == '0) || (rem_r == 3'd1 && q_push);
  assign accept      = in_ch.valid && in_ch.ready;

  // pick the op at the current slot
  logic [2:0] pre_end;
  logic [2:0] mid_end;
  logic [2:0] post_end;
  logic [2:0] post_idx;

  always_comb begin
    pre_end   = {1'b0, pre_cnt_r};
    mid_end   = pre_end + {2'd0, mid_v_r};
    post_end  = mid_end + {1'b0, post_cnt_r};
    post_idx  = slot_r - mid_end;
    q_op.last = (rem_r == 3'd1);
    if (slot_r < pre_end) begin
      q_op.kind   = KIND_POINT;
      q_op.cp     = {13'd0, pre_b_r[slot_r[1:0]]};
      q_op.nbytes = 3'd1;
    end else if (slot_r < mid_end) begin
      q_op.kind   = KIND_POINT;
      q_op.cp     = mid_cp_r;
      q_op.nbytes = mid_nb_r;
    end else if (slot_r < post_end) begin
      q_op.kind   = KIND_POINT;
      q_op.cp     = {13'd0, post_b_r[post_idx[1:0]]};
      q_op.nbytes = 3'd1;
    end else begin
      q_op.kind   = KIND_SUMMARY;
      q_op.cp     = '0;
      q_op.nbytes = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_b_r   <= pend_b_nxt;
      pre_b_r    <= pend_b_r;
      pre_cnt_r  <= d_pre_cnt;
      mid_v_r    <= d_mid_v;
      mid_cp_r   <= d_mid_cp;
      mid_nb_r   <= d_mid_nb;
      post_b_r   <= pend_b_nxt;
      post_cnt_r <= d_post_cnt;
      sum_r      <= d_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_cnt_r <= '0;
      exp_len_r  <= '0;
      drop_r     <= 1'b0;
      rem_r      <= '0;
      slot_r     <= '0;
    end else if (accept) begin
      pend_cnt_r <= pend_cnt_nxt;
      exp_len_r  <= exp_len_nxt;
      drop_r     <= drop_nxt;
      rem_r      <= d_total;
      slot_r     <= '0;
    end else if (q_push) begin
      rem_r      <= rem_r - 3'd1;
      slot_r     <= slot_r + 3'd1;
    end
  end

  `UCW_ASSERT_HOLDS(fe_slot_bound, rem_r != '0, ({1'b0, slot_r} + {1'b0, rem_r}) <= 4'd5)
  `UCW_ASSERT_HOLDS(fe_summary_last, q_push && sum_r && q_op.kind == KIND_SUMMARY, q_op.last)

endmodule

FILE: hdl/ucw_back.sv
// ----------------------------------------------------------------------------
// UTF-8 column wrap counter: counting back
// Applies queued ops to the column and row counters and drives the result
// register; a summary runs the row divider when width and column are nonzero.
// ----------------------------------------------------------------------------
`include "utf8_column_wrap_counter_core_defines.svh"

module ucw_back
  import ucw_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ucw_cfg_if.sink     cfg_ch,
  input  logic        q_valid,
  input  ucw_op_t     q_op,
  output logic        q_pop,
  ucw_out_if.source   out_ch
);

  localparam logic ST_RUN = 1'b0;
  localparam logic ST_DIV = 1'b1;
  localparam logic [COUNT_BITS-1:0] COUNT_SAT = '1;

  logic                  st_r;
  logic [WW_BITS-1:0]    ww_r;
  logic [COUNT_BITS-1:0] col_r;
  logic [COUNT_BITS-1:0] row_r;
  logic [WW_BITS-1:0]    rcol_r;

  logic [COUNT_BITS-1:0] col_nxt;
  logic [COUNT_BITS-1:0] row_nxt;
  logic [WW_BITS-1:0]    rcol_nxt;
  logic                  fresh_row;
  logic                  pt_w;

  logic                  o_valid_r;
  logic                  o_kind_r;
  logic [CP_BITS-1:0]    o_cp_r;
  logic [2:0]            o_nb_r;
  logic                  o_dw_r;
  logic [COUNT_BITS-1:0] o_scol_r;
  logic [COUNT_BITS-1:0] o_row_r;
  logic                  o_snr_r;
  logic [COUNT_BITS-1:0] o_total_r;
  logic [COUNT_BITS-1:0] o_lines_r;
  logic                  o_last_r;

  logic                  can_load;
  logic                  is_sum;
  logic                  do_point;
  logic                  sum_quick;
  logic                  div_start;
  logic                  div_fin;
  logic                  emit_sum;
  logic                  div_busy;
  logic [COUNT_BITS-1:0] div_quo;
  logic                  div_rem_nz;
  logic [COUNT_BITS-1:0] lines;

  ucw_div #(.COUNT_BITS(COUNT_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (col_r),
    .divisor  (ww_r),
    .busy     (div_busy),
    .quo      (div_quo),
    .rem_nz   (div_rem_nz)
  );

  assign cfg_ch.ready = 1'b1;

  assign can_load  = !o_valid_r || out_ch.ready;
  assign is_sum    = (q_op.kind == KIND_SUMMARY);
  assign do_point  = q_valid && st_r == ST_RUN && !is_sum && can_load;
  assign sum_quick = q_valid && st_r == ST_RUN && is_sum && (ww_r == '0 || col_r == '0)
                     && can_load;
  assign div_start = q_valid && st_r == ST_RUN && is_sum && ww_r != '0 && col_r != '0;
  assign div_fin   = (st_r == ST_DIV) && !div_busy && can_load;
  assign emit_sum  = sum_quick || div_fin;
  assign q_pop     = do_point || emit_sum;

  assign lines = sum_quick ? COUNT_BITS'(1) : div_quo + COUNT_BITS'(div_rem_nz);

  always_comb begin
    pt_w      = point_width(q_op.cp);
    col_nxt   = col_r;
    row_nxt   = row_r;
    rcol_nxt  = rcol_r;
    fresh_row = 1'b0;
    if (pt_w) begin
      if (ww_r != '0) begin
        if (rcol_r >= ww_r) begin
          // row full: wrap before placing this point
          if (row_r != COUNT_SAT) row_nxt = row_r + 1'b1;
          rcol_nxt  = '0;
          fresh_row = 1'b1;
        end
        rcol_nxt = rcol_nxt + 1'b1;
      end
      if (col_r != COUNT_SAT) col_nxt = col_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_point) begin
      o_kind_r  <= KIND_POINT;
      o_cp_r    <= q_op.cp;
      o_nb_r    <= q_op.nbytes;
      o_dw_r    <= pt_w;
      o_scol_r  <= col_r;
      o_row_r   <= row_nxt;
      o_snr_r   <= fresh_row;
      o_total_r <= '0;
      o_lines_r <= '0;
      o_last_r  <= q_op.last;
    end else if (emit_sum) begin
      o_kind_r  <= KIND_SUMMARY;
      o_cp_r    <= '0;
      o_nb_r    <= '0;
      o_dw_r    <= 1'b0;
      o_scol_r  <= '0;
      o_row_r   <= '0;
      o_snr_r   <= 1'b0;
      o_total_r <= col_r;
      o_lines_r <= lines;
      o_last_r  <= q_op.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_RUN;
      ww_r      <= WRAP_WIDTH_RESET;
      col_r     <= '0;
      row_r     <= '0;
      rcol_r    <= '0;
      o_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) ww_r <= cfg_ch.wrap_width;

      if (div_start)    st_r <= ST_DIV;
      else if (div_fin) st_r <= ST_RUN;

      if (do_point) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        rcol_r <= rcol_nxt;
      end else if (emit_sum) begin
        col_r  <= '0;
        row_r  <= '0;
        rcol_r <= '0;
      end

      if (do_point || emit_sum) o_valid_r <= 1'b1;
      else if (out_ch.ready)    o_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid          = o_valid_r;
  assign out_ch.item_kind      = o_kind_r;
  assign out_ch.code_point     = o_cp_r;
  assign out_ch.byte_count     = o_nb_r;
  assign out_ch.display_width  = o_dw_r;
  assign out_ch.start_column   = o_scol_r;
  assign out_ch.row_index      = o_row_r;
  assign out_ch.starts_new_row = o_snr_r;
  assign out_ch.total_columns  = o_total_r;
  assign out_ch.visual_lines   = o_lines_r;
  assign out_ch.last_of_run    = o_last_r;

  `UCW_ASSERT_HOLDS(bk_div_on_summary, st_r == ST_DIV, q_valid && q_op.kind == KIND_SUMMARY)
  `UCW_ASSERT_NEXT(bk_summary_clears, emit_sum, col_r == '0 && row_r == '0 && rcol_r == '0)

endmodule

FILE: hdl/utf8_column_wrap_counter_core.sv
// ----------------------------------------------------------------------------
// UTF-8 column wrap counter core
// Ops pass from the front's registers through the op queue to the result register.
// Throughput: 1 byte per cycle unless stalled; a byte that yields several results
// holds the front, and a summary that needs the row divider holds the back.
// Reset clears the counters, the op queue and any partial sequence; wrap width is 80.
// ----------------------------------------------------------------------------
module utf8_column_wrap_counter_core
  import ucw_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  ucw_in_if.sink     in_ch,
  ucw_out_if.source  out_ch,
  ucw_cfg_if.sink    cfg_ch
);

  logic    q_push;
  ucw_op_t q_push_op;
  logic    q_full;
  logic    q_pop;
  logic    q_valid;
  ucw_op_t q_head;

  ucw_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_push (q_push),
    .q_op   (q_push_op),
    .q_full (q_full)
  );

  ucw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (q_push_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_op    (q_head)
  );

  ucw_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_ch  (cfg_ch),
    .q_valid (q_valid),
    .q_op    (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
